[design/double_ended_queue_assert.svh]
// Assertion macros for the double-ended queue. Clock and reset names are fixed.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg)
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/deq_pkg.sv]
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int ITEM_WIDTH         = 32;

   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_LIST       = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Operation broadcast to every cell of the chain in a cycle.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_ROTATE
   } cell_op_type;

endpackage

[design/deq_cell.sv]
module deq_cell #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  deq_pkg::cell_op_type    op,
   input  logic [DATA_WIDTH-1:0]   push_value,
   input  logic [DATA_WIDTH-1:0]   left_value,
   input  logic                    left_valid,
   input  logic [DATA_WIDTH-1:0]   right_value,
   input  logic                    right_valid,
   input  logic [DATA_WIDTH-1:0]   wrap_value,
   output logic [DATA_WIDTH-1:0]   value,
   output logic                    valid,
   output logic                    tail
);

   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (op)
         deq_pkg::OP_PUSH_FRONT: begin
            value_in = left_value;
            valid_in = left_valid;
         end
         deq_pkg::OP_PUSH_BACK: begin
            // Only the first free cell behind the occupied run takes the item.
            if (!valid_ff && left_valid) begin
               value_in = push_value;
               valid_in = 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            value_in = right_value;
            valid_in = right_valid;
         end
         deq_pkg::OP_POP_BACK: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         deq_pkg::OP_ROTATE: begin
            // The tail cell takes the front value so the run comes back intact.
            if (valid_ff) begin
               value_in = right_valid ? right_value : wrap_value;
            end
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign tail  = valid_ff && !right_valid;

endmodule

[design/deq_chain.sv]
module deq_chain #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  deq_pkg::cell_op_type    op,
   input  logic [DATA_WIDTH-1:0]   push_value,
   output logic [DATA_WIDTH-1:0]   head_value,
   output logic [DATA_WIDTH-1:0]   tail_value
);

   logic [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_tail;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_value, right_value;
      logic                  left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_value = push_value;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      deq_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .push_value  (push_value),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .wrap_value  (cell_value[0]),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .tail        (cell_tail[i])
      );
   end

   // At most one cell is the tail, so an AND-OR select picks its value.
   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_value = tail_value | ({DATA_WIDTH{cell_tail[i]}} & cell_value[i]);
      end
   end

   assign head_value = cell_value[0];

endmodule

[design/deq_ctrl.sv]
`include "double_ended_queue_assert.svh"

module deq_ctrl #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [DATA_WIDTH-1:0]   rsp_value,
   output deq_pkg::status_type     rsp_status,
   output logic                    rsp_last,
   input  logic [DATA_WIDTH-1:0]   head_value,
   input  logic [DATA_WIDTH-1:0]   tail_value,
   output deq_pkg::cell_op_type    op
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      remaining_ff, remaining_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   deq_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free, accept, is_full, is_empty;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = count_ff == CNT_W'(DEPTH);
   assign is_empty   = count_ff == '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remaining_in  = remaining_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      op            = deq_pkg::OP_HOLD;
      if (accept) begin
         case (deq_pkg::req_code_type'(req_tuser))
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               if (is_full) begin
                  rsp_status_in = deq_pkg::ST_FULL;
               end else begin
                  rsp_status_in = deq_pkg::ST_OK;
                  count_in      = count_ff + 1'b1;
                  op = (req_tuser == deq_pkg::REQ_PUSH_FRONT) ? deq_pkg::OP_PUSH_FRONT
                                                               : deq_pkg::OP_PUSH_BACK;
               end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (is_empty) begin
                  rsp_status_in = deq_pkg::ST_UNDERFLOW;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = deq_pkg::ST_OK;
                  count_in      = count_ff - 1'b1;
                  if (req_tuser == deq_pkg::REQ_POP_FRONT) begin
                     rsp_value_in = head_value;
                     op           = deq_pkg::OP_POP_FRONT;
                  end else begin
                     rsp_value_in = tail_value;
                     op           = deq_pkg::OP_POP_BACK;
                  end
               end
            end
            deq_pkg::REQ_LIST: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = deq_pkg::ST_EMPTY;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in     = S_LIST;
                  remaining_in = count_ff;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end else if (state_ff == S_LIST && out_free) begin
         // Emit the front element and rotate the chain by one cell.
         rsp_valid_in  = 1'b1;
         rsp_value_in  = head_value;
         rsp_status_in = deq_pkg::ST_OK;
         rsp_last_in   = remaining_ff == CNT_W'(1);
         op            = deq_pkg::OP_ROTATE;
         remaining_in  = remaining_ff - 1'b1;
         if (remaining_ff == CNT_W'(1)) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   `DEQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `DEQ_ASSERT_IMP(a_list_remaining, state_ff == S_LIST,
      remaining_ff != '0 && remaining_ff <= count_ff, "listing counter out of range")
   `DEQ_ASSERT_NEXT(a_push_count,
      accept && !is_full && (req_tuser == deq_pkg::REQ_PUSH_FRONT ||
                             req_tuser == deq_pkg::REQ_PUSH_BACK),
      count_ff == $past(count_ff) + 1'b1, "push did not grow the queue")
   `DEQ_ASSERT_IMP(a_error_last, rsp_valid_ff && rsp_status_ff != deq_pkg::ST_OK,
      rsp_last_ff && rsp_value_ff == '0, "error item not final or not zero")

endmodule

[design/double_ended_queue.sv]
// Channel   Ports  tdata               tuser          tlast
// request   req_   item_value [31:0]   req_type [2:0]  -
// response  rsp_   out_value [31:0]    status [1:0]    last
//
// A push or pop is answered in the cycle after acceptance, a pop with its item;
// one may follow every cycle while the response side keeps up.
// A non-empty listing holds the request side until every element is sent, one
// per cycle while the response keeps up; the chain rotates one cell per element.
// Reset is synchronous and empties the queue at once; there is no clearing pass.
// A stalled response holds the output register and stalls the request side.
module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // item_value
   input  logic [2:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_value
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   logic signed [63:0]       item_ext;
   logic [DATA_WIDTH-1:0]    push_value;
   logic [DATA_WIDTH-1:0]    head_value, tail_value, rsp_value;
   logic signed [63:0]       rsp_ext;
   deq_pkg::cell_op_type     op;
   deq_pkg::status_type      rsp_status;

   assign item_ext   = 64'($signed(req_tdata));
   assign push_value = item_ext[DATA_WIDTH-1:0];

   deq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .push_value (push_value),
      .head_value (head_value),
      .tail_value (tail_value)
   );

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast),
      .head_value (head_value),
      .tail_value (tail_value),
      .op         (op)
   );

   // Stored values are sign extended from their own width on the way out.
   assign rsp_ext   = 64'($signed(rsp_value));
   assign rsp_tdata = rsp_ext[31:0];
   assign rsp_tuser = rsp_status;

endmodule
